// ===== rtl/uint_to_ascii_radix_core_defines.svh =====
// Assertion macros shared by the radix converter modules.
`ifndef UINT_TO_ASCII_RADIX_CORE_DEFINES_SVH
`define UINT_TO_ASCII_RADIX_CORE_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define UTAR_CHECK(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define UTAR_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/utar_pkg.sv =====
// Package: widths, codes, command/status types and the digit-to-ASCII map.
package utar_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int RADIX_W     = 8;
    localparam int CHAR_W      = 8;
    localparam int DIGIT_W     = 4;

    // Dividend bits retired per division cycle.
    localparam int DIV_BITS  = 8;
    localparam int DIV_STEPS = (VALUE_WIDTH + DIV_BITS - 1) / DIV_BITS;
    localparam int DIV_W     = DIV_STEPS * DIV_BITS;
    localparam int STEP_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

    // Digit stack: at most one digit per value bit (radix 2).
    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

    localparam logic [RADIX_W-1:0] MIN_RADIX   = 8'd2;
    localparam logic [RADIX_W-1:0] MAX_RADIX   = 8'd16;
    localparam int                 RADIX_REG_W = $clog2(16 + 1);

    localparam logic [DIGIT_W-1:0] DEC_DIGITS = 4'd10;
    localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0]  CHAR_A     = 8'h61;
    localparam logic [CHAR_W-1:0]  CHAR_NONE  = 8'h00;

    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_BAD_RADIX = 1'b1;

    typedef struct packed {
        logic load;
        logic div_step;
        logic pop;
        logic err;
    } t_cmd;

    typedef struct packed {
        logic radix_bad;
        logic step_last;
        logic quot_zero;
        logic stack_one;
        logic stack_empty;
    } t_sts;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        if (d < DEC_DIGITS) begin
            return CHAR_ZERO + CHAR_W'(d);
        end else begin
            return CHAR_A + CHAR_W'(d - DEC_DIGITS);
        end
    endfunction

endpackage

// ===== rtl/utar_if.sv =====
// Channel interfaces: conversion request in, character item out.
interface utar_in_if;
    import utar_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [VALUE_WIDTH-1:0] value;
    logic [RADIX_W-1:0]     radix;

    modport source (output valid, output value, output radix, input ready);
    modport sink   (input valid, input value, input radix, output ready);
endinterface

interface utar_out_if;
    import utar_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              status;
    logic              last;

    modport source (output valid, output char_code, output status, output last,
                    input ready);
    modport sink   (input valid, input char_code, input status, input last,
                    output ready);
endinterface

// ===== rtl/utar_dp.sv =====
// Datapath: shift-subtract divider, digit stack and output payload register.
module utar_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [utar_pkg::VALUE_WIDTH-1:0] i_value,
    input  logic [utar_pkg::RADIX_W-1:0]     i_radix,
    input  utar_pkg::t_cmd                  i_cmd,
    output utar_pkg::t_sts                  o_sts,
    output logic [utar_pkg::CHAR_W-1:0]     o_char_code,
    output logic                            o_status,
    output logic                            o_last
);
    import utar_pkg::*;

    logic [DIV_W-1:0]       r_div;
    logic [RADIX_REG_W-1:0] r_radix;
    logic [DIGIT_W-1:0]     r_rem;
    logic [STEP_W-1:0]      r_step;
    logic [DIGIT_W-1:0]     r_stack [VALUE_WIDTH];
    logic [CNT_W-1:0]       r_cnt;
    logic [CHAR_W-1:0]      r_char;
    logic                   r_status;
    logic                   r_last;

    logic [DIV_W-1:0]       n_div;
    logic [DIGIT_W-1:0]     n_rem;
    logic [DIGIT_W:0]       s_trial;

    // Retire DIV_BITS dividend bits: quotient bits shift in at the bottom.
    always_comb begin
        n_rem   = r_rem;
        n_div   = r_div;
        s_trial = '0;
        for (int j = 0; j < DIV_BITS; j++) begin
            s_trial = {n_rem, n_div[DIV_W-1]};
            n_div   = {n_div[DIV_W-2:0], 1'b0};
            if (s_trial >= (DIGIT_W+1)'(r_radix)) begin
                n_rem    = DIGIT_W'(s_trial - (DIGIT_W+1)'(r_radix));
                n_div[0] = 1'b1;
            end else begin
                n_rem = DIGIT_W'(s_trial);
            end
        end
    end

    always_comb begin
        o_sts.radix_bad   = (i_radix < MIN_RADIX) || (i_radix > MAX_RADIX);
        o_sts.step_last   = (r_step == STEP_W'(DIV_STEPS - 1));
        o_sts.quot_zero   = (n_div == '0);
        o_sts.stack_one   = (r_cnt == CNT_W'(1));
        o_sts.stack_empty = (r_cnt == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            if (i_cmd.load) begin
                r_cnt <= '0;
            end else if (i_cmd.div_step && o_sts.step_last) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (i_cmd.pop) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_div   <= DIV_W'(i_value);
            r_radix <= RADIX_REG_W'(i_radix);
            r_rem   <= '0;
            r_step  <= '0;
        end else if (i_cmd.div_step) begin
            r_div <= n_div;
            if (o_sts.step_last) begin
                // Digit done: push it and restart on the quotient.
                r_rem      <= '0;
                r_step     <= '0;
                r_stack[0] <= n_rem;
                for (int i = 1; i < VALUE_WIDTH; i++) begin
                    r_stack[i] <= r_stack[i-1];
                end
            end else begin
                r_rem  <= n_rem;
                r_step <= r_step + STEP_W'(1);
            end
        end else if (i_cmd.pop) begin
            for (int i = 0; i < VALUE_WIDTH - 1; i++) begin
                r_stack[i] <= r_stack[i+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pop) begin
            r_char   <= digit_char(r_stack[0]);
            r_status <= STATUS_OK;
            r_last   <= o_sts.stack_one;
        end else if (i_cmd.err) begin
            r_char   <= CHAR_NONE;
            r_status <= STATUS_BAD_RADIX;
            r_last   <= 1'b1;
        end
    end

    assign o_char_code = r_char;
    assign o_status    = r_status;
    assign o_last      = r_last;

    `include "uint_to_ascii_radix_core_defines.svh"

    `UTAR_CHECK(a_div_radix_ok, i_cmd.div_step, (r_radix >= RADIX_REG_W'(MIN_RADIX)) && (r_radix <= RADIX_REG_W'(MAX_RADIX)), "division running on an invalid radix")
    `UTAR_CHECK(a_rem_below_radix, i_cmd.div_step, (RADIX_REG_W'(r_rem) < r_radix), "partial remainder not below radix")
    `UTAR_CHECK(a_stack_no_overflow, i_cmd.div_step && o_sts.step_last, (r_cnt < CNT_W'(VALUE_WIDTH)), "digit stack overflow")

endmodule

// ===== rtl/utar_ctrl.sv =====
// Controller: sequences load, division, digit emission and error items.
module utar_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic           i_out_ready,
    output logic           o_out_valid,
    output utar_pkg::t_cmd o_cmd,
    input  utar_pkg::t_sts i_sts
);
    import utar_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_EMIT,
        S_ERR
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   s_out_free;

    // The output register can take a new item when empty or being drained.
    assign s_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_sts.radix_bad ? S_ERR : S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.step_last && i_sts.quot_zero) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (s_out_free) begin
                    o_cmd.pop = 1'b1;
                    if (i_sts.stack_one) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_ERR: begin
                if (s_out_free) begin
                    o_cmd.err = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.pop || o_cmd.err) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    `include "uint_to_ascii_radix_core_defines.svh"

    `UTAR_CHECK(a_emit_has_digits, r_state == S_EMIT, !i_sts.stack_empty, "emitting from an empty digit stack")
    `UTAR_CHECK_NEXT(a_good_radix_divides, o_cmd.load && !i_sts.radix_bad, r_state == S_DIV, "valid radix did not start division")
    `UTAR_CHECK_NEXT(a_last_pop_idles, o_cmd.pop && i_sts.stack_one, (r_state == S_IDLE) && r_out_valid, "final digit did not end the conversion")

endmodule

// ===== rtl/uint_to_ascii_radix_core.sv =====
// Top level: unsigned value to ASCII digit string converter.
//
// Converts an unsigned VALUE_WIDTH-bit value into ASCII digits in a radix
// from 2 to 16, one character item per digit, most significant first, with
// last set on the final character. Digits 0-9 map to '0'-'9' and 10-15 to
// 'a'-'f' in every radix; a zero value gives the single character '0'. A
// radix of 0, 1 or above 16 gives one item with char_code 0, status 1 and
// last 1. One conversion is in flight at a time: the input is ready only
// while the block is idle. A conversion is accepted, divided digit by digit
// (the shift-subtract divider retires 8 dividend bits a cycle and runs the
// full width for each digit), then emitted one character per digit as the
// output takes them. Digits are produced least significant first and held
// in a VALUE_WIDTH-deep stack, which reverses them for emission. The output
// register lets the next request be accepted while the final character still
// waits to be taken.
module uint_to_ascii_radix_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    utar_in_if.sink           i_in,
    utar_out_if.source        o_out
);
    import utar_pkg::*;

    t_cmd s_cmd;
    t_sts s_sts;

    // Sequence the conversion; owns both handshakes.
    utar_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (s_cmd),
        .i_sts       (s_sts)
    );

    // Divide, stack digits, hold the outgoing character.
    utar_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_value     (i_in.value),
        .i_radix     (i_in.radix),
        .i_cmd       (s_cmd),
        .o_sts       (s_sts),
        .o_char_code (o_out.char_code),
        .o_status    (o_out.status),
        .o_last      (o_out.last)
    );

endmodule
